/* rtl/core/lae_pkg.sv */
// Shared types, codes and helpers for the Langton's ant grid engine.
// No dependencies; used by the channel interfaces, the engine and the testbench.
package lae_pkg;

  localparam int MAX_GRID_WIDTH_DEF  = 128;
  localparam int MAX_GRID_HEIGHT_DEF = 128;

  localparam int EXT_W   = 8;   // width of the extent registers
  localparam int COORD_W = 16;  // ant coordinates, two's complement
  localparam int LIVE_W  = 15;  // reported live count
  localparam int CFG_IDX_W = 1;

  localparam logic [EXT_W-1:0] EXT_RESET = 8'd128;

  // command codes
  localparam logic [1:0] CMD_STEP   = 2'd0;
  localparam logic [1:0] CMD_TOGGLE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // heading codes, clockwise with rows growing downward
  localparam logic [1:0] HD_RIGHT = 2'd0;
  localparam logic [1:0] HD_DOWN  = 2'd1;
  localparam logic [1:0] HD_LEFT  = 2'd2;
  localparam logic [1:0] HD_UP    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;
  localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] cell_x;
    logic [6:0] cell_y;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ant_x;
    logic signed [COORD_W-1:0] ant_y;
    logic [1:0]                heading;
    logic                      cell_written;
    logic                      cell_changed;
    logic                      off_grid;
    logic [LIVE_W-1:0]         live_count;
  } res_t;

  // zero reads as one, anything above the maximum saturates
  function automatic logic [EXT_W-1:0] clamp_extent(input logic [EXT_W-1:0] v,
                                                    input int unsigned maxv);
    logic [EXT_W-1:0] r;
    r = v;
    if (v == '0) r = 8'd1;
    else if (32'(v) > maxv) r = 8'(maxv);
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat_inc(input logic [COORD_W-1:0] c);
    return (c == COORD_MAX) ? c : c + 16'd1;
  endfunction

  function automatic logic [COORD_W-1:0] sat_dec(input logic [COORD_W-1:0] c);
    return (c == COORD_MIN) ? c : c - 16'd1;
  endfunction

  function automatic logic outside(input logic [COORD_W-1:0] col,
                                   input logic [COORD_W-1:0] row,
                                   input logic [EXT_W-1:0]   gw,
                                   input logic [EXT_W-1:0]   gh);
    return col[COORD_W-1] || row[COORD_W-1] ||
           (col >= {8'h00, gw}) || (row >= {8'h00, gh});
  endfunction

endpackage

/* rtl/core/lae_if.sv */
// Valid/ready channels for command items and result items.
// Depends on lae_pkg for the payload structs.
interface lae_cmd_if;
  logic          valid;
  logic          ready;
  lae_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lae_res_if;
  logic          valid;
  logic          ready;
  lae_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/langtons_ant_grid_engine.sv */
// Langton's ant engine: control, ant state and live count around the row store.
// Depends on lae_pkg, lae_if (channels) and lae_cell_mem.
//
//   channel   dir  handshake          payload
//   cmd       in   valid/ready        command, cell_x, cell_y
//   result    out  valid/ready        ant_x, ant_y, heading, cell_written,
//                                     cell_changed, off_grid, live_count
//   cfg       in   cfg_we             cfg_index, cfg_data
//
// Step, toggle and the unused code go through S_MODIFY: accept with the row read
// (for a step or toggle on the grid), then modify and write back the row once
// the read data is out of the memory. Clear zeroes one row per cycle in S_CLEAR.
// After rst the same row sweep runs, and cmd.ready rises once it has ended.
// A finished result waits in the output register while the next item is
// accepted; that item's write-back waits for the register.
module langtons_ant_grid_engine #(
  parameter int MAX_GRID_WIDTH  = lae_pkg::MAX_GRID_WIDTH_DEF,
  parameter int MAX_GRID_HEIGHT = lae_pkg::MAX_GRID_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lae_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lae_pkg::EXT_W-1:0]       cfg_data,
  lae_cmd_if.sink                         cmd,
  lae_res_if.source                       result
);
  import lae_pkg::*;

  localparam int COL_W = $clog2(MAX_GRID_WIDTH);
  localparam int ROW_W = $clog2(MAX_GRID_HEIGHT);
  localparam int CNT_W = $clog2(MAX_GRID_WIDTH * MAX_GRID_HEIGHT + 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_GRID_HEIGHT - 1);
  localparam logic [EXT_W-1:0] GW_RESET = clamp_extent(EXT_RESET, MAX_GRID_WIDTH);
  localparam logic [EXT_W-1:0] GH_RESET = clamp_extent(EXT_RESET, MAX_GRID_HEIGHT);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MODIFY = 4'b0010,
    S_CLEAR  = 4'b0100,
    S_POST   = 4'b1000
  } state_t;

  state_t st, st_next;

  logic [EXT_W-1:0]   gw, gh;
  logic [COORD_W-1:0] ant_col, ant_col_next;
  logic [COORD_W-1:0] ant_row, ant_row_next;
  logic [1:0]         hd, hd_next;
  logic [CNT_W-1:0]   live, live_next;

  logic [1:0]       op_cmd;
  logic             op_hit;
  logic [COL_W-1:0] op_col;
  logic [ROW_W-1:0] op_row;
  logic [ROW_W-1:0] clr_row;
  logic             clr_post;

  logic             res_valid;
  res_t             res, res_next;
  logic             out_free;
  logic             post;

  logic                      mem_re, mem_we;
  logic [ROW_W-1:0]          mem_raddr, mem_waddr;
  logic [MAX_GRID_WIDTH-1:0] mem_rdata, mem_wdata;

  logic cmd_acc;
  logic ant_in, tog_in;
  logic bit_old;
  logic [1:0] turned;

  lae_cell_mem #(
    .ROWS (MAX_GRID_HEIGHT),
    .COLS (MAX_GRID_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  assign cmd.ready      = (st == S_IDLE);
  assign cmd_acc        = cmd.valid && cmd.ready;
  assign out_free       = !res_valid || result.ready;
  assign result.valid   = res_valid;
  assign result.payload = res;

  assign ant_in = !outside(ant_col, ant_row, gw, gh);
  assign tog_in = ({1'b0, cmd.payload.cell_x} < gw) && ({1'b0, cmd.payload.cell_y} < gh);

  // read the row on accept
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ant_row[ROW_W-1:0];
    if (cmd_acc) begin
      unique case (cmd.payload.command)
        CMD_STEP: begin
          mem_re = ant_in;
        end
        CMD_TOGGLE: begin
          mem_re    = tog_in;
          mem_raddr = ROW_W'(cmd.payload.cell_y);
        end
        default: begin
          mem_re = 1'b0;
        end
      endcase
    end
  end

  assign bit_old = mem_rdata[op_col];
  assign turned  = bit_old ? hd + 2'd1 : hd + 2'd3;

  always_comb begin
    st_next      = st;
    ant_col_next = ant_col;
    ant_row_next = ant_row;
    hd_next      = hd;
    live_next    = live;
    mem_we       = 1'b0;
    mem_waddr    = op_row;
    mem_wdata    = mem_rdata;
    post         = 1'b0;
    res_next     = res;
    res_next.cell_written = 1'b0;
    res_next.cell_changed = 1'b0;

    unique case (st)
      S_IDLE: begin
        if (cmd_acc) begin
          st_next = (cmd.payload.command == CMD_CLEAR) ? S_CLEAR : S_MODIFY;
        end
      end
      S_MODIFY: begin
        if (out_free) begin
          post    = 1'b1;
          st_next = S_IDLE;
          if (op_hit && (op_cmd == CMD_STEP || op_cmd == CMD_TOGGLE)) begin
            mem_we            = 1'b1;
            mem_wdata[op_col] = ~bit_old;
            live_next = bit_old ? live - CNT_W'(1) : live + CNT_W'(1);
            res_next.cell_written = ~bit_old;
            res_next.cell_changed = 1'b1;
          end
          if (op_cmd == CMD_STEP) begin
            if (op_hit) hd_next = turned;
            unique case (hd_next)
              HD_RIGHT: ant_col_next = sat_inc(ant_col);
              HD_DOWN:  ant_row_next = sat_inc(ant_row);
              HD_LEFT:  ant_col_next = sat_dec(ant_col);
              HD_UP:    ant_row_next = sat_dec(ant_row);
              default:  ant_row_next = ant_row;
            endcase
          end
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_row;
        mem_wdata = '0;
        if (clr_row == LAST_ROW) st_next = S_POST;
      end
      S_POST: begin
        if (!clr_post) begin
          st_next = S_IDLE;
        end else if (out_free) begin
          post         = 1'b1;
          st_next      = S_IDLE;
          ant_col_next = COORD_W'({1'b0, gw[EXT_W-1:1]});
          ant_row_next = COORD_W'({1'b0, gh[EXT_W-1:1]});
          hd_next      = HD_RIGHT;
          live_next    = '0;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase

    res_next.ant_x    = $signed(ant_col_next);
    res_next.ant_y    = $signed(ant_row_next);
    res_next.heading  = hd_next;
    res_next.off_grid = outside(ant_col_next, ant_row_next, gw, gh);
    res_next.live_count = (32'(live_next) > 32'd32767) ? 15'h7FFF
                                                       : LIVE_W'(live_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_CLEAR;
      gw        <= GW_RESET;
      gh        <= GH_RESET;
      ant_col   <= COORD_W'({1'b0, GW_RESET[EXT_W-1:1]});
      ant_row   <= COORD_W'({1'b0, GH_RESET[EXT_W-1:1]});
      hd        <= HD_RIGHT;
      live      <= '0;
      clr_row   <= '0;
      clr_post  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      st      <= st_next;
      ant_col <= ant_col_next;
      ant_row <= ant_row_next;
      hd      <= hd_next;
      live    <= live_next;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  gw <= clamp_extent(cfg_data, MAX_GRID_WIDTH);
          REG_GRID_HEIGHT: gh <= clamp_extent(cfg_data, MAX_GRID_HEIGHT);
          default:         gw <= gw;
        endcase
      end

      if (cmd_acc && cmd.payload.command == CMD_CLEAR) begin
        clr_row  <= '0;
        clr_post <= 1'b1;
      end else if (st == S_CLEAR && clr_row != LAST_ROW) begin
        clr_row <= clr_row + ROW_W'(1);
      end

      if (post) res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (post) res <= res_next;
    if (cmd_acc) begin
      op_cmd <= cmd.payload.command;
      if (cmd.payload.command == CMD_TOGGLE) begin
        op_hit <= tog_in;
        op_col <= COL_W'(cmd.payload.cell_x);
        op_row <= ROW_W'(cmd.payload.cell_y);
      end else begin
        op_hit <= (cmd.payload.command == CMD_STEP) && ant_in;
        op_col <= ant_col[COL_W-1:0];
        op_row <= ant_row[ROW_W-1:0];
      end
    end
  end

  // a row read is always consumed by the modify cycle that follows
  a_read_then_modify: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> st == S_MODIFY)
    else $error("row read not followed by modify");

  // write-back and result posting go together outside the clear sweep
  a_write_posts: assert property (@(posedge clk) disable iff (rst)
    (mem_we && st == S_MODIFY) |=> result.valid && result.payload.cell_changed)
    else $error("cell write without a reported change");

  // no item is taken while the store is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (st == S_CLEAR || st == S_POST) |-> !cmd.ready)
    else $error("command accepted during clear sweep");

endmodule

/* rtl/core/lae_cell_mem.sv */
// Cell grid store: one row of cells per entry, one write and one read port,
// registered read data. Depends on nothing but its parameters.
module lae_cell_mem #(
  parameter int ROWS = 128,
  parameter int COLS = 128
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  output logic [COLS-1:0]         rd_data,
  input  logic                    wr_en,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [COLS-1:0]         wr_data
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sim/tb_langtons_ant_grid_engine.sv */
`timescale 1ns / 100ps
// Testbench for langtons_ant_grid_engine: drives command items and extent writes,
// tracks grid, ant and live count in a small class and checks every result item.
// Depends on lae_pkg, lae_if and the engine RTL.
module tb_langtons_ant_grid_engine;
  import lae_pkg::*;

  localparam int GRID_COLS   = MAX_GRID_WIDTH_DEF;
  localparam int GRID_ROWS   = MAX_GRID_HEIGHT_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD   = 300;
  localparam int WALK_STEPS  = 12;
  localparam int LIVE_MAX    = 32767;

  class ant_tracker;
    bit [GRID_COLS*GRID_ROWS-1:0] cells;
    int         col;
    int         row;
    logic [1:0] hd;
    int         live;
    int         cols_used;
    int         rows_used;
    res_t       due_reports[$];
    int         mismatches;
    int         checked;
    int         n_step, n_toggle, n_clear, n_nop;

    function new();
      cells = '0;
      live = 0;
      cols_used = int'(EXT_RESET);
      rows_used = int'(EXT_RESET);
      go_home();
      mismatches = 0;
      checked = 0;
      n_step = 0;
      n_toggle = 0;
      n_clear = 0;
      n_nop = 0;
    endfunction

    function void go_home();
      col = cols_used / 2;
      row = rows_used / 2;
      hd = HD_RIGHT;
    endfunction

    function bit ant_off();
      return col < 0 || row < 0 || col >= cols_used || row >= rows_used;
    endfunction

    // one cell along an axis, saturating at the 16-bit signed range
    function int nudge(int c, int d);
      int n;
      n = c + d;
      if (n > 32767) n = 32767;
      else if (n < -32768) n = -32768;
      return n;
    endfunction

    function void set_extent(logic [CFG_IDX_W-1:0] idx, logic [EXT_W-1:0] v);
      int e;
      e = (v == '0) ? 1 : int'(v);
      if (idx == REG_GRID_WIDTH) cols_used = (e > GRID_COLS) ? GRID_COLS : e;
      else rows_used = (e > GRID_ROWS) ? GRID_ROWS : e;
    endfunction

    function int outstanding();
      return due_reports.size();
    endfunction

    function string describe(res_t r);
      return $sformatf("x=%0d y=%0d hd=%0d wr=%0b chg=%0b off=%0b live=%0d",
                       r.ant_x, r.ant_y, r.heading, r.cell_written, r.cell_changed,
                       r.off_grid, r.live_count);
    endfunction

    function void apply_command(cmd_t c);
      res_t e;
      int   idx;
      e = '0;
      case (c.command)
        CMD_STEP: begin
          n_step++;
          // off the grid the ant just keeps going straight
          if (!ant_off()) begin
            idx = row * GRID_COLS + col;
            if (cells[idx]) begin
              cells[idx] = 1'b0;
              live--;
              hd = hd + 2'd1;
              e.cell_written = 1'b0;
            end else begin
              cells[idx] = 1'b1;
              live++;
              hd = hd - 2'd1;
              e.cell_written = 1'b1;
            end
            e.cell_changed = 1'b1;
          end
          case (hd)
            HD_RIGHT: col = nudge(col, 1);
            HD_DOWN:  row = nudge(row, 1);
            HD_LEFT:  col = nudge(col, -1);
            default:  row = nudge(row, -1);
          endcase
        end
        CMD_TOGGLE: begin
          n_toggle++;
          if (int'(c.cell_x) < cols_used && int'(c.cell_y) < rows_used) begin
            idx = int'(c.cell_y) * GRID_COLS + int'(c.cell_x);
            cells[idx] = ~cells[idx];
            if (cells[idx]) live++;
            else live--;
            e.cell_written = cells[idx];
            e.cell_changed = 1'b1;
          end
        end
        CMD_CLEAR: begin
          n_clear++;
          cells = '0;
          live = 0;
          go_home();
        end
        default: n_nop++;
      endcase
      e.ant_x = 16'(col);
      e.ant_y = 16'(row);
      e.heading = hd;
      e.off_grid = ant_off();
      e.live_count = LIVE_W'((live > LIVE_MAX) ? LIVE_MAX : live);
      due_reports.push_back(e);
    endfunction

    function void check_report(res_t r);
      res_t e;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %s", describe(r));
        return;
      end
      e = due_reports.pop_front();
      checked++;
      if (r.ant_x !== e.ant_x || r.ant_y !== e.ant_y || r.heading !== e.heading ||
          r.cell_written !== e.cell_written || r.cell_changed !== e.cell_changed ||
          r.off_grid !== e.off_grid || r.live_count !== e.live_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected %s, got %s", $time, describe(e), describe(r));
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [EXT_W-1:0]     cfg_data;

  lae_cmd_if cmd_ch();
  lae_res_if res_ch();

  ant_tracker tr = new();
  bit idling;
  bit long_hold_req;
  int quiet_cycles = 0;
  int settings_used = 1;

  langtons_ant_grid_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .result    (res_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   r;
    r = $urandom_range(0, 99);
    c.cell_x = 7'($urandom_range(0, 127));
    c.cell_y = 7'($urandom_range(0, 127));
    if (r < 70) begin
      c.command = CMD_STEP;
    end else if (r < 90) begin
      c.command = CMD_TOGGLE;
      // keep most toggles inside the extents in use
      if ($urandom_range(0, 3) != 0) begin
        c.cell_x = 7'($urandom_range(0, tr.cols_used - 1));
        c.cell_y = 7'($urandom_range(0, tr.rows_used - 1));
      end
    end else if (r < 95) begin
      c.command = CMD_CLEAR;
    end else begin
      c.command = CMD_NOP;
    end
    return c;
  endfunction

  task automatic send_cmd(input logic [1:0] op, input logic [6:0] x, input logic [6:0] y);
    cmd_t c;
    int   gap;
    c.command = op;
    c.cell_x = x;
    c.cell_y = y;
    gap = (idling && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.payload <= c;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    tr.apply_command(c);
  endtask

  // stop offering items and wait until every result item is back
  task automatic settle();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (tr.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_extents(input logic [EXT_W-1:0] w, input logic [EXT_W-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    tr.set_extent(REG_GRID_WIDTH, w);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    tr.set_extent(REG_GRID_HEIGHT, h);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic random_phase(input logic [EXT_W-1:0] w, input logic [EXT_W-1:0] h,
                              input int n, input bit idle_on, input int hold_at,
                              input int pause_at);
    cmd_t c;
    settle();
    set_extents(w, h);
    idling = idle_on;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      if (i == pause_at) settle();
      c = random_cmd();
      send_cmd(c.command, c.cell_x, c.cell_y);
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall;
    int hold;
    stall = 0;
    hold = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) tr.check_report(res_ch.payload);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD;
      end
      if (hold > 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        res_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        stall = gap_len() - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles, %0d results pending",
               quiet_cycles, tr.outstanding());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    idling = 1'b1;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: both turns, toggles at the corners, unused code, clear
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    send_cmd(CMD_STEP, 7'd127, 7'd127);
    send_cmd(CMD_TOGGLE, 7'd64, 7'd64);
    send_cmd(CMD_TOGGLE, 7'd0, 7'd0);
    send_cmd(CMD_TOGGLE, 7'd127, 7'd127);
    send_cmd(CMD_TOGGLE, 7'd127, 7'd127);
    send_cmd(CMD_NOP, 7'd127, 7'd127);
    send_cmd(CMD_STEP, 7'd127, 7'd0);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    send_cmd(CMD_CLEAR, 7'd0, 7'd0);
    send_cmd(CMD_TOGGLE, 7'd64, 7'd64);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    // zero width reads as one, oversized height saturates; ant is left off grid
    settle();
    set_extents(8'd0, 8'd255);
    send_cmd(CMD_TOGGLE, 7'd1, 7'd0);
    send_cmd(CMD_TOGGLE, 7'd0, 7'd127);
    send_cmd(CMD_TOGGLE, 7'd0, 7'd0);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    send_cmd(CMD_CLEAR, 7'd0, 7'd0);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    send_cmd(CMD_TOGGLE, 7'd127, 7'd0);

    // straight walks off a 1x1 grid, once upward and once downward
    settle();
    set_extents(8'd1, 8'd1);
    idling = 1'b0;
    send_cmd(CMD_CLEAR, 7'd0, 7'd0);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    repeat (WALK_STEPS)
      send_cmd(CMD_STEP, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    send_cmd(CMD_CLEAR, 7'd0, 7'd0);
    send_cmd(CMD_TOGGLE, 7'd0, 7'd0);
    send_cmd(CMD_STEP, 7'd0, 7'd0);
    repeat (WALK_STEPS)
      send_cmd(CMD_STEP, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));

    random_phase(8'd128, 8'd128, 200, 1'b1, 100, 150);
    random_phase(8'd0, 8'd255, 80, 1'b1, -1, -1);
    random_phase(8'd7, 8'd5, 150, 1'b1, -1, -1);
    random_phase(8'd1, 8'd1, 60, 1'b1, -1, -1);
    random_phase(8'd128, 8'd2, 100, 1'b0, -1, -1);
    random_phase(8'd3, 8'd128, 100, 1'b1, 40, -1);
    random_phase(8'd200, 8'd0, 60, 1'b1, -1, -1);
    random_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 150, 1'b1, -1, -1);

    settle();
    repeat (12) @(posedge clk);
    if (tr.outstanding() != 0) $display("%0d result items never arrived", tr.outstanding());
    $display("covered %0d steps, %0d toggles, %0d clears, %0d unused codes over %0d extent settings",
             tr.n_step, tr.n_toggle, tr.n_clear, tr.n_nop, settings_used);
    $display("checked %0d result items, walked the ant off a one-cell grid both ways, %0d mismatches",
             tr.checked, tr.mismatches);
    if (tr.mismatches == 0 && tr.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
